[hw/rtl/lmcs_pkg.sv]
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types and constants for the LED matrix column scanner.
// ----------------------------------------------------------------------------
package lmcs_pkg;

    localparam int MAX_COLUMNS_DEF = 8;
    localparam int MAX_ROWS_DEF    = 8;

    // compare width: holds counts up to 31
    localparam int CMP_W     = 5;
    localparam int COUNT_W   = 4;
    localparam int PERIOD_W  = 16;
    localparam int CELL_W    = 3;
    localparam int POS_W     = 3;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_REFRESH = 2'd1,
        ACT_WRITE   = 2'd2
    } action_t;

    localparam logic [CELL_W-1:0] COLOR_OFF         = 3'd0;
    localparam logic [CELL_W-1:0] COLOR_RED         = 3'd1;
    localparam logic [CELL_W-1:0] COLOR_GREEN       = 3'd2;
    localparam logic [CELL_W-1:0] COLOR_FLASH_RED   = 3'd3;
    localparam logic [CELL_W-1:0] COLOR_FLASH_GREEN = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_PERIOD = 2'd2;

    localparam logic [COUNT_W-1:0]  COLUMN_COUNT_RST = 4'd6;
    localparam logic [COUNT_W-1:0]  ROW_COUNT_RST    = 4'd5;
    localparam logic [PERIOD_W-1:0] HALF_PERIOD_RST  = 16'd500;

endpackage

[hw/rtl/led_matrix_column_scanner.sv]
// ----------------------------------------------------------------------------
// led_matrix_column_scanner
// Column-multiplexed scan driver for a two-color LED matrix with blink.
// ----------------------------------------------------------------------------
// Every input word (tick, refresh or cell write) is handled when accepted, so
// the block sustains one word per cycle while not stalled. A refresh word puts
// its result in the output register on the following edge; the input stalls
// only while that register holds a word the downstream side has not taken. The
// frame store is a small register array read at the scanned column, so no
// clearing pass is needed after reset.
module led_matrix_column_scanner
    import lmcs_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // cell_column, cell_row, cell_color
    input  logic [1:0]           s_tuser,   // action

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // column_select_n, red_rows,
                                            // green_rows, scanned_column

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_data
);

    localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RD_ROWS = (MAX_ROWS < MASK_W) ? MAX_ROWS : MASK_W;

    logic [CELL_W-1:0]   frame_reg [MAX_COLUMNS][MAX_ROWS];
    logic [COL_W-1:0]    scan_col_reg, scan_col_next;
    logic [PERIOD_W-1:0] blink_timer_reg, blink_timer_next;
    logic                blink_on_reg, blink_on_next;

    logic [COUNT_W-1:0]  column_count_reg;
    logic [COUNT_W-1:0]  row_count_reg;
    logic [PERIOD_W-1:0] half_period_reg;

    logic                m_valid_reg, m_valid_next;
    logic [MASK_W-1:0]   col_sel_n_reg, col_sel_n_next;
    logic [MASK_W-1:0]   red_reg, red_next;
    logic [MASK_W-1:0]   green_reg, green_next;
    logic [POS_W-1:0]    scanned_reg, scanned_next;

    action_t             action;
    logic [POS_W-1:0]    cell_column;
    logic [POS_W-1:0]    cell_row;
    logic [CELL_W-1:0]   cell_color;
    logic                s_fire;
    logic                wr_en;

    logic [CMP_W-1:0]    ncols, nrows, cur_ext, next_ext;
    logic [COL_W-1:0]    cur_col;
    logic [PERIOD_W-1:0] timer_inc, limit;
    logic                blink_wrap;
    logic [CELL_W-1:0]   code;

    assign action      = action_t'(s_tuser);
    assign cell_column = s_tdata[2:0];
    assign cell_row    = s_tdata[5:3];
    assign cell_color  = s_tdata[8:6];

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, scanned_reg, green_reg, red_reg, col_sel_n_reg};

    always_comb begin
        ncols = CMP_W'(column_count_reg);
        if (ncols == '0) begin
            ncols = CMP_W'(1);
        end
        if (ncols > CMP_W'(MAX_COLUMNS)) begin
            ncols = CMP_W'(MAX_COLUMNS);
        end
        nrows = CMP_W'(row_count_reg);
        if (nrows > CMP_W'(MAX_ROWS)) begin
            nrows = CMP_W'(MAX_ROWS);
        end

        cur_col  = (CMP_W'(scan_col_reg) >= ncols) ? '0 : scan_col_reg;
        cur_ext  = CMP_W'(cur_col);
        next_ext = cur_ext + CMP_W'(1);

        limit      = (half_period_reg == '0) ? PERIOD_W'(1) : half_period_reg;
        timer_inc  = blink_timer_reg + PERIOD_W'(1);
        blink_wrap = timer_inc >= limit;

        wr_en = 1'b0;
        scan_col_next    = scan_col_reg;
        blink_timer_next = blink_timer_reg;
        blink_on_next    = blink_on_reg;
        m_valid_next     = m_valid_reg && !m_tready;

        if (s_fire) begin
            unique case (action)
                ACT_TICK: begin
                    blink_timer_next = blink_wrap ? '0 : timer_inc;
                    blink_on_next    = blink_on_reg ^ blink_wrap;
                end
                ACT_REFRESH: begin
                    m_valid_next  = 1'b1;
                    scan_col_next = (next_ext == ncols) ? '0 : COL_W'(next_ext);
                end
                ACT_WRITE: begin
                    wr_en = (CMP_W'(cell_column) < ncols) && (CMP_W'(cell_row) < nrows)
                            && (cell_color <= COLOR_FLASH_GREEN);
                end
                default: begin
                end
            endcase
        end

        for (int i = 0; i < MASK_W; i++) begin
            col_sel_n_next[i] = (CMP_W'(i) != cur_ext);
        end
        red_next   = '0;
        green_next = '0;
        code       = COLOR_OFF;
        for (int r = 0; r < RD_ROWS; r++) begin
            code = (CMP_W'(r) < nrows) ? frame_reg[cur_col][r] : COLOR_OFF;
            if (code == COLOR_RED || (code == COLOR_FLASH_RED && blink_on_reg)) begin
                red_next[r] = 1'b1;
            end else if (code == COLOR_GREEN ||
                         (code == COLOR_FLASH_GREEN && blink_on_reg)) begin
                green_next[r] = 1'b1;
            end
        end
        scanned_next = POS_W'(cur_col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_col_reg     <= '0;
            blink_timer_reg  <= '0;
            blink_on_reg     <= 1'b1;
            m_valid_reg      <= 1'b0;
            column_count_reg <= COLUMN_COUNT_RST;
            row_count_reg    <= ROW_COUNT_RST;
            half_period_reg  <= HALF_PERIOD_RST;
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                for (int r = 0; r < MAX_ROWS; r++) begin
                    frame_reg[c][r] <= COLOR_OFF;
                end
            end
        end else begin
            scan_col_reg    <= scan_col_next;
            blink_timer_reg <= blink_timer_next;
            blink_on_reg    <= blink_on_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_COLUMN_COUNT:      column_count_reg <= cfg_data[COUNT_W-1:0];
                    REG_ROW_COUNT:         row_count_reg    <= cfg_data[COUNT_W-1:0];
                    REG_BLINK_HALF_PERIOD: half_period_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                for (int r = 0; r < MAX_ROWS; r++) begin
                    if (wr_en && CMP_W'(cell_column) == CMP_W'(c)
                              && CMP_W'(cell_row) == CMP_W'(r)) begin
                        frame_reg[c][r] <= cell_color;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && action == ACT_REFRESH) begin
            col_sel_n_reg <= col_sel_n_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            scanned_reg   <= scanned_next;
        end
    end

    a_refresh_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && action == ACT_REFRESH |=> m_valid_reg)
        else $error("refresh did not produce an output word");

    a_colors_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (red_reg & green_reg) == '0)
        else $error("a row lit red and green at once");

    a_one_column_driven: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $countones(~col_sel_n_reg) <= 1)
        else $error("more than one column driven");

    a_blink_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && action == ACT_TICK && blink_wrap
        |=> blink_on_reg != $past(blink_on_reg) && blink_timer_reg == '0)
        else $error("blink phase did not toggle at half period");

endmodule
